>>> rtl/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg: shared types and constants of the row cell legalizer
// Widths, the load word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rcl_pkg;
  localparam int MaxBlocks = 64;
  localparam int IdxW      = 6;
  localparam int CntW      = 7;
  localparam int PosW      = 24;
  localparam int WidW      = 16;
  localparam int ExtW      = 28;
  localparam int QDepth    = 2;

  localparam logic [1:0] CFG_ROW_LEFT  = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH = 2'd1;
  localparam logic [1:0] CFG_TAP_SPACE = 2'd2;
  localparam logic [1:0] CFG_PACK_MODE = 2'd3;

  typedef struct packed {
    logic                   store;
    logic                   last;
    logic signed [PosW-1:0] left;
    logic [WidW-1:0]        width;
    logic                   tap;
  } load_word_t;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [ExtW-1:0] v);
    logic signed [ExtW-1:0] hi;
    logic signed [ExtW-1:0] lo;
    begin
      hi = ExtW'(signed'({1'b0, {(PosW-1){1'b1}}}));
      lo = -hi - ExtW'(1);
      if (v > hi) sat_pos = hi[PosW-1:0];
      else if (v < lo) sat_pos = lo[PosW-1:0];
      else sat_pos = v[PosW-1:0];
    end
  endfunction
endpackage

>>> rtl/rcl_front.sv
// ----------------------------------------------------------------------------
// rcl_front: input stage
// Takes cells, counts the row, marks cells beyond the store so that the back
// end drops them, and queues load words for the back end.
// ----------------------------------------------------------------------------
module rcl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic signed [rcl_pkg::PosW-1:0] cell_left,
  input  logic [rcl_pkg::WidW-1:0]        cell_width,
  input  logic                            is_tap,
  input  logic                            last_cell,
  input  logic                            pop,
  output logic                            q_valid,
  output logic                            q_full,
  output rcl_pkg::load_word_t             q_word
);
  import rcl_pkg::*;

  load_word_t     q_r [QDepth];
  logic [1:0]     cnt_r, cnt_nxt;
  logic           rd_r, wr_r;
  logic [CntW-1:0] fill_r, fill_nxt;
  load_word_t     w;

  // classify: store only while room remains
  always_comb begin
    w.store = (fill_r < CntW'(MaxBlocks));
    w.last  = last_cell;
    w.left  = cell_left;
    w.width = cell_width;
    w.tap   = is_tap;
    fill_nxt = fill_r;
    if (take) begin
      if (last_cell) fill_nxt = '0;
      else if (w.store) fill_nxt = fill_r + CntW'(1);
    end
    cnt_nxt = cnt_r + 2'(take) - 2'(pop);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (take) q_r[wr_r] <= w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; fill_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      if (take) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_full  = (cnt_r == 2'(QDepth));
  assign q_word  = q_r[rd_r];
endmodule

>>> rtl/rcl_back.sv
// ----------------------------------------------------------------------------
// rcl_back: store, sort, passes and result emission
// Stable insertion sort of load positions, a forward contour pass and, in
// loose mode, a backward one, then results in load order. All stores are read
// with registered data, one address per store per cycle.
// ----------------------------------------------------------------------------
module rcl_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  rcl_pkg::load_word_t             q_word,
  output logic                            pop,
  output logic                            idle,
  input  logic signed [rcl_pkg::PosW-1:0] row_left,
  input  logic [rcl_pkg::PosW-2:0]        row_width,
  input  logic [rcl_pkg::WidW-1:0]        tap_spacing,
  input  logic                            pack_mode,
  output logic                            out_valid,
  output logic [rcl_pkg::IdxW-1:0]        out_cell_index,
  output logic signed [rcl_pkg::PosW-1:0] out_new_left,
  output logic                            out_last_result
);
  import rcl_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_SINIT, S_SRD, S_SCMP, S_FRD, S_FWT, S_FWD, S_BRD, S_BWT, S_BWD,
    S_ERD, S_EMIT
  } state_t;

  state_t state_r;
  logic signed [PosW-1:0] left_mem  [MaxBlocks];
  logic [WidW-1:0]        width_mem [MaxBlocks];
  logic                   tap_mem   [MaxBlocks];
  logic [IdxW-1:0]        order_mem [MaxBlocks];
  logic signed [PosW-1:0] sortl_mem [MaxBlocks];
  logic signed [ExtW-1:0] pos_mem   [MaxBlocks];

  logic [CntW-1:0] n_r, i_r, j_r;
  logic [IdxW-1:0] cur_r, oc_r;
  logic signed [PosW-1:0] curl_r, ol_r;
  logic signed [ExtW-1:0] cont_r, p_r;
  logic [WidW-1:0] cw_r;
  logic ct_r;
  logic signed [ExtW-1:0] cw_x, gap_x, f_pos, right, b_pos;

  assign pop  = (state_r == S_LOAD) && q_valid;
  assign idle = (state_r == S_LOAD);

  // pass arithmetic
  always_comb begin
    cw_x  = signed'(ExtW'(cw_r));
    gap_x = (ct_r && !pack_mode) ? signed'(ExtW'(tap_spacing)) : ExtW'(0);
    f_pos = (pack_mode || (p_r < cont_r)) ? cont_r : p_r;
    right = p_r + cw_x;
    if (right > cont_r) right = cont_r;
    b_pos = right - cw_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; n_r <= '0; i_r <= '0; j_r <= '0;
      out_valid <= 1'b0; out_cell_index <= '0; out_new_left <= '0;
      out_last_result <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        // store words, start on last
        S_LOAD: begin
          if (pop) begin
            if (q_word.store) begin
              left_mem[n_r[IdxW-1:0]]  <= q_word.left;
              width_mem[n_r[IdxW-1:0]] <= q_word.width;
              tap_mem[n_r[IdxW-1:0]]   <= q_word.tap;
              n_r <= n_r + CntW'(1);
            end
            if (q_word.last) begin
              i_r <= '0;
              state_r <= S_SINIT;
            end
          end
        end
        // insertion: fetch cell i
        S_SINIT: begin
          if (i_r == n_r) begin
            i_r <= '0;
            cont_r <= ExtW'(row_left);
            state_r <= S_FRD;
          end else begin
            cur_r  <= i_r[IdxW-1:0];
            curl_r <= left_mem[i_r[IdxW-1:0]];
            j_r    <= i_r;
            state_r <= S_SRD;
          end
        end
        // insertion: read the sorted neighbor below j
        S_SRD: begin
          if (j_r == '0) begin
            order_mem[0] <= cur_r;
            sortl_mem[0] <= curl_r;
            i_r <= i_r + CntW'(1);
            state_r <= S_SINIT;
          end else begin
            oc_r <= order_mem[j_r[IdxW-1:0] - IdxW'(1)];
            ol_r <= sortl_mem[j_r[IdxW-1:0] - IdxW'(1)];
            state_r <= S_SCMP;
          end
        end
        // insertion: shift the neighbor up or drop the cell in place
        S_SCMP: begin
          if (ol_r > curl_r) begin
            order_mem[j_r[IdxW-1:0]] <= oc_r;
            sortl_mem[j_r[IdxW-1:0]] <= ol_r;
            j_r <= j_r - CntW'(1);
            state_r <= S_SRD;
          end else begin
            order_mem[j_r[IdxW-1:0]] <= cur_r;
            sortl_mem[j_r[IdxW-1:0]] <= curl_r;
            i_r <= i_r + CntW'(1);
            state_r <= S_SINIT;
          end
        end
        // forward pass: read the next cell in sorted order
        S_FRD: begin
          if (i_r == n_r) begin
            if (pack_mode) begin
              i_r <= '0;
              state_r <= S_ERD;
            end else begin
              cont_r <= ExtW'(row_left) + signed'(ExtW'(row_width));
              state_r <= S_BRD;
            end
          end else begin
            oc_r <= order_mem[i_r[IdxW-1:0]];
            p_r  <= ExtW'(sortl_mem[i_r[IdxW-1:0]]);
            state_r <= S_FWT;
          end
        end
        S_FWT: begin
          cw_r <= width_mem[oc_r];
          ct_r <= tap_mem[oc_r];
          state_r <= S_FWD;
        end
        // forward pass: place the cell, advance the contour
        S_FWD: begin
          pos_mem[oc_r] <= f_pos;
          cont_r <= f_pos + cw_x + gap_x;
          i_r <= i_r + CntW'(1);
          state_r <= S_FRD;
        end
        // backward pass: read cells in reverse sorted order
        S_BRD: begin
          if (i_r == '0) begin
            state_r <= S_ERD;
          end else begin
            oc_r <= order_mem[i_r[IdxW-1:0] - IdxW'(1)];
            state_r <= S_BWT;
          end
        end
        S_BWT: begin
          p_r  <= pos_mem[oc_r];
          cw_r <= width_mem[oc_r];
          ct_r <= tap_mem[oc_r];
          state_r <= S_BWD;
        end
        // backward pass: pull the cell left of the contour
        S_BWD: begin
          pos_mem[oc_r] <= b_pos;
          cont_r <= b_pos - gap_x;
          i_r <= i_r - CntW'(1);
          state_r <= S_BRD;
        end
        // emit in load order
        S_ERD: begin
          if (i_r == n_r) begin
            n_r <= '0;
            state_r <= S_LOAD;
          end else begin
            p_r <= pos_mem[i_r[IdxW-1:0]];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid       <= 1'b1;
          out_cell_index  <= i_r[IdxW-1:0];
          out_new_left    <= sat_pos(p_r);
          out_last_result <= (i_r + CntW'(1) == n_r);
          if (i_r + CntW'(1) == n_r) begin
            n_r <= '0;
            state_r <= S_LOAD;
          end else begin
            i_r <= i_r + CntW'(1);
            state_r <= S_ERD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

>>> rtl/row_cell_legalizer.sv
// ----------------------------------------------------------------------------
// row_cell_legalizer: one-row cell legalizer
// Top level: configuration registers, input queue and legalizing engine.
// ----------------------------------------------------------------------------
// Cells are accepted one per cycle (start high, busy low) into a two-word
// queue and stored by the engine; a cell beyond the 64-entry store is dropped,
// and the cell marked last starts the row. busy then stays high until the
// row's final result has been shown, so the next row waits for the whole row.
// The stable insertion sort fetches each cell, then reads the earlier sorted
// cells one by one from the top, shifting each larger one up, until the cell
// drops into place; the forward pass and, in loose mode, the backward pass
// read, fetch and place each cell in turn; results then come out in load
// order, each shown for exactly one cycle on out_valid; the receiver cannot
// stall them. busy is high while the queue is full or a row is being worked.
module row_cell_legalizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [rcl_pkg::PosW-1:0] in_cell_left,
  input  logic [rcl_pkg::WidW-1:0]        in_cell_width,
  input  logic                            in_is_tap,
  input  logic                            in_last_cell,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rcl_pkg::PosW-1:0]        cfg_data,
  output logic                            out_valid,
  output logic [rcl_pkg::IdxW-1:0]        out_cell_index,
  output logic signed [rcl_pkg::PosW-1:0] out_new_left,
  output logic                            out_last_result
);
  import rcl_pkg::*;

  logic signed [PosW-1:0] row_left_r;
  logic [PosW-2:0]        row_width_r;
  logic [WidW-1:0]        tap_spacing_r;
  logic                   pack_mode_r;
  logic take, pop, q_valid, q_full, idle, rowq_r;
  load_word_t q_word;

  // hold busy from a last cell until the row is done
  assign busy = q_full || rowq_r;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_left_r <= '0; row_width_r <= '0; tap_spacing_r <= '0;
      pack_mode_r <= 1'b0; rowq_r <= 1'b0;
    end else begin
      if (take && in_last_cell) rowq_r <= 1'b1;
      else if (idle && !q_valid && out_valid && out_last_result) rowq_r <= 1'b0;
      else if (idle && !q_valid && !out_valid && rowq_r && !pop) rowq_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_LEFT:  row_left_r    <= cfg_data;
          CFG_ROW_WIDTH: row_width_r   <= cfg_data[PosW-2:0];
          CFG_TAP_SPACE: tap_spacing_r <= cfg_data[WidW-1:0];
          CFG_PACK_MODE: pack_mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  rcl_front u_front (
    .clk, .rst_n, .take,
    .cell_left(in_cell_left), .cell_width(in_cell_width),
    .is_tap(in_is_tap), .last_cell(in_last_cell),
    .pop, .q_valid, .q_full, .q_word
  );

  rcl_back u_back (
    .clk, .rst_n, .q_valid, .q_word, .pop, .idle,
    .row_left(row_left_r), .row_width(row_width_r),
    .tap_spacing(tap_spacing_r), .pack_mode(pack_mode_r),
    .out_valid, .out_cell_index, .out_new_left, .out_last_result
  );
endmodule

>>> rtl/rcl_checker.sv
// ----------------------------------------------------------------------------
// rcl_checker: port-level checks of the row cell legalizer
// Watches start, busy and the result strobe.
// ----------------------------------------------------------------------------
module rcl_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_cell,
  input logic out_valid,
  input logic out_last_result
);
  // a last cell accepted makes the block busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_cell |=> busy) else $error("not busy after last cell");
  // results appear only while busy
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  // no word follows the final word of a row at once
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("word right after final word");
endmodule

bind row_cell_legalizer rcl_checker u_rcl_checker (
  .clk, .rst_n, .start, .busy, .in_last_cell, .out_valid, .out_last_result
);
